>>> design/jts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jts_pkg: shared types and constants of the json token scanner
// token codes, scan modes, result records, literal spelling and number grammar
// ----------------------------------------------------------------------------
package jts_pkg;

  localparam int unsigned TOKEN_LENGTH_W = 16;

  typedef enum logic [3:0] {
    TOK_LBRACE  = 4'd0,
    TOK_RBRACE  = 4'd1,
    TOK_LSQUARE = 4'd2,
    TOK_RSQUARE = 4'd3,
    TOK_COMMA   = 4'd4,
    TOK_COLON   = 4'd5,
    TOK_STRCHAR = 4'd6,
    TOK_STREND  = 4'd7,
    TOK_NUMCHAR = 4'd8,
    TOK_NUMEND  = 4'd9,
    TOK_NULL    = 4'd10,
    TOK_TRUE    = 4'd11,
    TOK_FALSE   = 4'd12,
    TOK_END     = 4'd13,
    TOK_INVALID = 4'd14
  } token_kind_e;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_LIT     = 4'd1,
    MODE_STR     = 4'd2,
    MODE_ESC     = 4'd3,
    MODE_HEX     = 4'd4,
    MODE_SIGN    = 4'd5,
    MODE_ZERO    = 4'd6,
    MODE_INT     = 4'd7,
    MODE_DOT     = 4'd8,
    MODE_FRAC    = 4'd9,
    MODE_EXP     = 4'd10,
    MODE_EXPSIGN = 4'd11,
    MODE_EXPDIG  = 4'd12
  } scan_mode_e;

  typedef enum logic [1:0] {
    LIT_NULL  = 2'd0,
    LIT_TRUE  = 2'd1,
    LIT_FALSE = 2'd2
  } lit_choice_e;

  // character codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LSQ    = 8'h5b;
  localparam logic [7:0] CH_RSQ    = 8'h5d;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LE     = 8'h65;
  localparam logic [7:0] CH_LF_LC  = 8'h66;
  localparam logic [7:0] CH_LN     = 8'h6e;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LU     = 8'h75;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UE     = 8'h45;
  localparam logic [7:0] CH_UF     = 8'h46;

  localparam logic [7:0] CTRL_MAX  = 8'h1f;
  localparam logic [7:0] BYTE_MAX  = 8'hff;

  typedef struct packed {
    scan_mode_e  mode;
    logic [2:0]  lit_pos;
    lit_choice_e lit_choice;
    logic [15:0] hex_value;
    logic [2:0]  hex_seen;
    logic        failed;
  } scan_state_t;

  typedef struct packed {
    token_kind_e                 token_kind;
    logic [7:0]                  char_value;
    logic [TOKEN_LENGTH_W-1:0]   token_length;
    logic                        last;
  } result_t;

  // r1 is only ever valid together with r0
  typedef struct packed {
    logic    r0_valid;
    result_t r0;
    logic    r1_valid;
    result_t r1;
  } result_pair_t;

  typedef struct packed {
    logic       err;
    scan_mode_e mode;
  } num_step_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

  // ok flag and nibble value of a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [7:0] v;
    v = 8'h00;
    if (is_digit(b)) begin
      v = b - CH_0;
      return {1'b1, v[3:0]};
    end else if ((b >= CH_LA) && (b <= CH_LF_LC)) begin
      v = b - CH_LA + 8'd10;
      return {1'b1, v[3:0]};
    end else if ((b >= CH_UA) && (b <= CH_UF)) begin
      v = b - CH_UA + 8'd10;
      return {1'b1, v[3:0]};
    end
    return 5'b0_0000;
  endfunction

  function automatic logic [2:0] lit_len(input lit_choice_e c);
    unique case (c)
      LIT_NULL:  return 3'd4;
      LIT_TRUE:  return 3'd4;
      LIT_FALSE: return 3'd5;
      default:   return 3'd0;
    endcase
  endfunction

  function automatic token_kind_e lit_kind(input lit_choice_e c);
    unique case (c)
      LIT_NULL:  return TOK_NULL;
      LIT_TRUE:  return TOK_TRUE;
      default:   return TOK_FALSE;
    endcase
  endfunction

  function automatic logic [7:0] lit_char(input lit_choice_e c, input logic [2:0] pos);
    unique case (c)
      LIT_NULL: begin
        unique case (pos)
          3'd0:    return 8'h6e;
          3'd1:    return 8'h75;
          3'd2:    return 8'h6c;
          3'd3:    return 8'h6c;
          default: return 8'h00;
        endcase
      end
      LIT_TRUE: begin
        unique case (pos)
          3'd0:    return 8'h74;
          3'd1:    return 8'h72;
          3'd2:    return 8'h75;
          3'd3:    return 8'h65;
          default: return 8'h00;
        endcase
      end
      LIT_FALSE: begin
        unique case (pos)
          3'd0:    return 8'h66;
          3'd1:    return 8'h61;
          3'd2:    return 8'h6c;
          3'd3:    return 8'h73;
          3'd4:    return 8'h65;
          default: return 8'h00;
        endcase
      end
      default: return 8'h00;
    endcase
  endfunction

  // next number mode; MODE_IDLE means the byte ends a complete number
  function automatic num_step_t num_next(input scan_mode_e m, input logic [7:0] b);
    logic d;
    logic e;
    num_step_t r;
    d = is_digit(b);
    e = (b == CH_LE) || (b == CH_UE);
    r.err  = 1'b0;
    r.mode = MODE_IDLE;
    unique case (m)
      MODE_SIGN: begin
        if (b == CH_0) r.mode = MODE_ZERO;
        else if (d)    r.mode = MODE_INT;
        else           r.err  = 1'b1;
      end
      MODE_ZERO: begin
        if (d)              r.err  = 1'b1;
        else if (b == CH_DOT) r.mode = MODE_DOT;
        else if (e)         r.mode = MODE_EXP;
      end
      MODE_INT: begin
        if (d)              r.mode = MODE_INT;
        else if (b == CH_DOT) r.mode = MODE_DOT;
        else if (e)         r.mode = MODE_EXP;
      end
      MODE_DOT: begin
        if (d) r.mode = MODE_FRAC;
        else   r.err  = 1'b1;
      end
      MODE_FRAC: begin
        if (d)      r.mode = MODE_FRAC;
        else if (e) r.mode = MODE_EXP;
      end
      MODE_EXP: begin
        if ((b == CH_PLUS) || (b == CH_MINUS)) r.mode = MODE_EXPSIGN;
        else if (d)                            r.mode = MODE_EXPDIG;
        else                                   r.err  = 1'b1;
      end
      MODE_EXPSIGN: begin
        if (d) r.mode = MODE_EXPDIG;
        else   r.err  = 1'b1;
      end
      default: begin
        if (d) r.mode = MODE_EXPDIG;
      end
    endcase
    return r;
  endfunction

  function automatic logic num_complete(input scan_mode_e m);
    return (m == MODE_ZERO) || (m == MODE_INT) || (m == MODE_FRAC) || (m == MODE_EXPDIG);
  endfunction

endpackage
`default_nettype wire

>>> design/jts_scan_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jts_scan_core: per-byte scanner step
// next scan state, next length count and up to two results for one request
// ----------------------------------------------------------------------------
module jts_scan_core #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic [7:0]                                     text_byte_i,
  input  logic                                           end_of_text_i,
  input  jts_pkg::scan_state_t                           state_i,
  input  logic [((LENGTH_BITS < 16) ? LENGTH_BITS : 16)-1:0] len_i,
  output jts_pkg::scan_state_t                           state_o,
  output logic [((LENGTH_BITS < 16) ? LENGTH_BITS : 16)-1:0] len_o,
  output jts_pkg::result_pair_t                          res_o
);

  localparam int unsigned CNT_W = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;

  logic [CNT_W-1:0]     len_inc;
  logic                 idle_emit;
  jts_pkg::result_t     idle_res;
  jts_pkg::scan_state_t idle_st;
  logic [CNT_W-1:0]     idle_len;
  jts_pkg::scan_state_t rst_st;
  jts_pkg::num_step_t   nstep;
  logic [4:0]           hx;
  logic [15:0]          hex_next;
  logic [7:0]           b;

  assign b       = text_byte_i;
  assign len_inc = (&len_i) ? len_i : len_i + CNT_W'(1);
  assign nstep   = jts_pkg::num_next(state_i.mode, b);
  assign hx      = jts_pkg::hex_digit(b);
  assign hex_next = {state_i.hex_value[11:0], hx[3:0]};

  always_comb begin
    rst_st            = '0;
    rst_st.mode       = jts_pkg::MODE_IDLE;
    rst_st.lit_choice = jts_pkg::LIT_NULL;
  end

  // what the byte does when scanned between tokens
  always_comb begin
    idle_st      = state_i;
    idle_st.mode = jts_pkg::MODE_IDLE;
    idle_len     = '0;
    idle_emit    = 1'b0;
    idle_res     = '0;
    if ((b == jts_pkg::CH_SPACE) || (b == jts_pkg::CH_CR) ||
        (b == jts_pkg::CH_LF) || (b == jts_pkg::CH_TAB)) begin
      idle_len = len_i;
    end else if (b == jts_pkg::CH_LBRACE) begin
      idle_emit = 1'b1;
      idle_res.token_kind = jts_pkg::TOK_LBRACE;
    end else if (b == jts_pkg::CH_RBRACE) begin
      idle_emit = 1'b1;
      idle_res.token_kind = jts_pkg::TOK_RBRACE;
    end else if (b == jts_pkg::CH_LSQ) begin
      idle_emit = 1'b1;
      idle_res.token_kind = jts_pkg::TOK_LSQUARE;
    end else if (b == jts_pkg::CH_RSQ) begin
      idle_emit = 1'b1;
      idle_res.token_kind = jts_pkg::TOK_RSQUARE;
    end else if (b == jts_pkg::CH_COMMA) begin
      idle_emit = 1'b1;
      idle_res.token_kind = jts_pkg::TOK_COMMA;
    end else if (b == jts_pkg::CH_COLON) begin
      idle_emit = 1'b1;
      idle_res.token_kind = jts_pkg::TOK_COLON;
    end else if (b == jts_pkg::CH_QUOTE) begin
      idle_st.mode = jts_pkg::MODE_STR;
    end else if ((b == jts_pkg::CH_LN) || (b == jts_pkg::CH_LT) ||
                 (b == jts_pkg::CH_LF_LC)) begin
      idle_st.mode    = jts_pkg::MODE_LIT;
      idle_st.lit_pos = 3'd1;
      if (b == jts_pkg::CH_LN)      idle_st.lit_choice = jts_pkg::LIT_NULL;
      else if (b == jts_pkg::CH_LT) idle_st.lit_choice = jts_pkg::LIT_TRUE;
      else                          idle_st.lit_choice = jts_pkg::LIT_FALSE;
    end else if ((b == jts_pkg::CH_MINUS) || jts_pkg::is_digit(b)) begin
      if (b == jts_pkg::CH_MINUS)  idle_st.mode = jts_pkg::MODE_SIGN;
      else if (b == jts_pkg::CH_0) idle_st.mode = jts_pkg::MODE_ZERO;
      else                         idle_st.mode = jts_pkg::MODE_INT;
      idle_len  = CNT_W'(1);
      idle_emit = 1'b1;
      idle_res.token_kind = jts_pkg::TOK_NUMCHAR;
      idle_res.char_value = b;
    end else begin
      idle_emit = 1'b1;
      idle_res.token_kind = jts_pkg::TOK_INVALID;
      idle_st.failed      = 1'b1;
    end
  end

  always_comb begin
    state_o = state_i;
    len_o   = len_i;
    res_o   = '0;
    if (end_of_text_i) begin
      state_o = rst_st;
      len_o   = '0;
      if (!state_i.failed && jts_pkg::num_complete(state_i.mode)) begin
        res_o.r0_valid            = 1'b1;
        res_o.r0.token_kind       = jts_pkg::TOK_NUMEND;
        res_o.r0.token_length     = jts_pkg::TOKEN_LENGTH_W'(len_i);
        res_o.r1_valid            = 1'b1;
        res_o.r1.token_kind       = jts_pkg::TOK_END;
      end else if (!state_i.failed && (state_i.mode != jts_pkg::MODE_IDLE)) begin
        res_o.r0_valid            = 1'b1;
        res_o.r0.token_kind       = jts_pkg::TOK_INVALID;
        res_o.r1_valid            = 1'b1;
        res_o.r1.token_kind       = jts_pkg::TOK_END;
      end else begin
        res_o.r0_valid            = 1'b1;
        res_o.r0.token_kind       = jts_pkg::TOK_END;
      end
    end else if (!state_i.failed) begin
      unique case (state_i.mode)
        jts_pkg::MODE_IDLE: begin
          state_o        = idle_st;
          len_o          = idle_len;
          res_o.r0_valid = idle_emit;
          res_o.r0       = idle_res;
        end
        jts_pkg::MODE_LIT: begin
          if ((state_i.lit_pos < jts_pkg::lit_len(state_i.lit_choice)) &&
              (b == jts_pkg::lit_char(state_i.lit_choice, state_i.lit_pos))) begin
            state_o.lit_pos = state_i.lit_pos + 3'd1;
            if (state_i.lit_pos + 3'd1 == jts_pkg::lit_len(state_i.lit_choice)) begin
              state_o.mode        = jts_pkg::MODE_IDLE;
              res_o.r0_valid      = 1'b1;
              res_o.r0.token_kind = jts_pkg::lit_kind(state_i.lit_choice);
            end
          end else begin
            state_o.mode        = jts_pkg::MODE_IDLE;
            state_o.failed      = 1'b1;
            res_o.r0_valid      = 1'b1;
            res_o.r0.token_kind = jts_pkg::TOK_INVALID;
          end
        end
        jts_pkg::MODE_STR: begin
          if (b == jts_pkg::CH_QUOTE) begin
            state_o.mode          = jts_pkg::MODE_IDLE;
            res_o.r0_valid        = 1'b1;
            res_o.r0.token_kind   = jts_pkg::TOK_STREND;
            res_o.r0.token_length = jts_pkg::TOKEN_LENGTH_W'(len_i);
          end else if (b <= jts_pkg::CTRL_MAX) begin
            state_o.mode        = jts_pkg::MODE_IDLE;
            state_o.failed      = 1'b1;
            res_o.r0_valid      = 1'b1;
            res_o.r0.token_kind = jts_pkg::TOK_INVALID;
          end else if (b == jts_pkg::CH_BSLASH) begin
            state_o.mode = jts_pkg::MODE_ESC;
          end else begin
            len_o               = len_inc;
            res_o.r0_valid      = 1'b1;
            res_o.r0.token_kind = jts_pkg::TOK_STRCHAR;
            res_o.r0.char_value = b;
          end
        end
        jts_pkg::MODE_ESC: begin
          state_o.mode        = jts_pkg::MODE_STR;
          res_o.r0_valid      = 1'b1;
          res_o.r0.token_kind = jts_pkg::TOK_STRCHAR;
          len_o               = len_inc;
          if ((b == jts_pkg::CH_QUOTE) || (b == jts_pkg::CH_SLASH) ||
              (b == jts_pkg::CH_BSLASH)) begin
            res_o.r0.char_value = b;
          end else if (b == jts_pkg::CH_LB) begin
            res_o.r0.char_value = jts_pkg::CH_BS;
          end else if (b == jts_pkg::CH_LF_LC) begin
            res_o.r0.char_value = jts_pkg::CH_FF;
          end else if (b == jts_pkg::CH_LN) begin
            res_o.r0.char_value = jts_pkg::CH_LF;
          end else if (b == jts_pkg::CH_LR) begin
            res_o.r0.char_value = jts_pkg::CH_CR;
          end else if (b == jts_pkg::CH_LT) begin
            res_o.r0.char_value = jts_pkg::CH_TAB;
          end else if (b == jts_pkg::CH_LU) begin
            // start of a four digit escape
            len_o             = len_i;
            res_o             = '0;
            state_o.mode      = jts_pkg::MODE_HEX;
            state_o.hex_value = '0;
            state_o.hex_seen  = '0;
          end else begin
            len_o               = len_i;
            state_o.mode        = jts_pkg::MODE_IDLE;
            state_o.failed      = 1'b1;
            res_o.r0.token_kind = jts_pkg::TOK_INVALID;
          end
        end
        jts_pkg::MODE_HEX: begin
          if (!hx[4]) begin
            state_o.mode        = jts_pkg::MODE_IDLE;
            state_o.failed      = 1'b1;
            res_o.r0_valid      = 1'b1;
            res_o.r0.token_kind = jts_pkg::TOK_INVALID;
          end else begin
            state_o.hex_value = hex_next;
            state_o.hex_seen  = state_i.hex_seen + 3'd1;
            if (state_i.hex_seen == 3'd3) begin
              res_o.r0_valid = 1'b1;
              if (hex_next <= 16'(jts_pkg::BYTE_MAX)) begin
                state_o.mode        = jts_pkg::MODE_STR;
                len_o               = len_inc;
                res_o.r0.token_kind = jts_pkg::TOK_STRCHAR;
                res_o.r0.char_value = hex_next[7:0];
              end else begin
                state_o.mode        = jts_pkg::MODE_IDLE;
                state_o.failed      = 1'b1;
                res_o.r0.token_kind = jts_pkg::TOK_INVALID;
              end
            end
          end
        end
        default: begin
          // number lexeme
          if (nstep.err) begin
            state_o.mode        = jts_pkg::MODE_IDLE;
            state_o.failed      = 1'b1;
            res_o.r0_valid      = 1'b1;
            res_o.r0.token_kind = jts_pkg::TOK_INVALID;
          end else if (nstep.mode == jts_pkg::MODE_IDLE) begin
            res_o.r0_valid        = 1'b1;
            res_o.r0.token_kind   = jts_pkg::TOK_NUMEND;
            res_o.r0.token_length = jts_pkg::TOKEN_LENGTH_W'(len_i);
            res_o.r1_valid        = idle_emit;
            res_o.r1              = idle_res;
            state_o               = idle_st;
            len_o                 = idle_len;
          end else begin
            state_o.mode        = nstep.mode;
            len_o               = len_inc;
            res_o.r0_valid      = 1'b1;
            res_o.r0.token_kind = jts_pkg::TOK_NUMCHAR;
            res_o.r0.char_value = b;
          end
        end
      endcase
    end

    // mark the final result of this request
    if (res_o.r1_valid) begin
      res_o.r1.last = 1'b1;
    end else if (res_o.r0_valid) begin
      res_o.r0.last = 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> design/jts_result_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jts_result_fifo: result queue
// takes up to two results per cycle and, when popped, hands out one per cycle
// ----------------------------------------------------------------------------
module jts_result_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  jts_pkg::result_pair_t push_i,
  input  logic                  pop_i,
  output logic                  room_two_o,
  output logic                  valid_o,
  output jts_pkg::result_t      head_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  jts_pkg::result_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] n_push;
  logic             do_pop;

  assign valid_o    = (count_q != '0);
  assign head_o     = mem_q[rd_ptr_q];
  assign room_two_o = (count_q <= CNT_W'(DEPTH - 2));
  assign do_pop     = pop_i && valid_o;
  assign n_push     = CNT_W'(push_i.r0_valid) + CNT_W'(push_i.r1_valid);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(n_push);
    rd_ptr_d = rd_ptr_q + PTR_W'(do_pop);
    count_d  = count_q + n_push - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.r0_valid) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.r1_valid) begin
      mem_q[wr_ptr_q + PTR_W'(1)] <= push_i.r1;
    end
  end

endmodule
`default_nettype wire

>>> design/json_token_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// json_token_scanner: streaming json lexer
// one text byte per request in, token events out
// ----------------------------------------------------------------------------
// The scanner takes one byte of JSON text per cycle and sustains that rate as
// long as the consumer keeps up. A request is held in an input register; from
// there the scan step (state update and up to two token events) is a short
// combinational path into a four-entry result queue, so a result passes the
// input register and the queue before it appears. Most bytes give zero or one
// event; a byte that ends a number and also starts a token, and end of text
// after a number or inside an unfinished token, gives two, which drain one per
// cycle from the queue unless the consumer stalls. The input stalls only while
// the queue has fewer than two free entries, so the output rate of one event
// per cycle is what bounds the throughput. Lengths of strings and numbers
// saturate at min(2^LENGTH_BITS - 1, 0xffff). After an invalid event all bytes
// are dropped until end of text, which always gives end and returns to reset.
// ----------------------------------------------------------------------------
module json_token_scanner #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request side
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  // result side
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_kind_o,
  output logic [7:0]  char_value_o,
  output logic [15:0] token_length_o,
  output logic        last_o
);

  localparam int unsigned CNT_W = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;

  // input register
  logic                  in_valid_q;
  logic [7:0]            in_byte_q;
  logic                  in_eot_q;

  // scanner state
  jts_pkg::scan_state_t  state_q, state_d;
  logic [CNT_W-1:0]      len_q, len_d;

  jts_pkg::result_pair_t res_pair;
  jts_pkg::result_pair_t push;
  jts_pkg::result_t      head;
  logic                  room_two;
  logic                  advance;

  // a buffered request moves on once the queue can absorb two events
  assign advance    = in_valid_q && room_two;
  assign in_stall_o = in_valid_q && !room_two;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= text_byte_i;
      in_eot_q  <= end_of_text_i;
    end
  end

  jts_scan_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_scan_core (
    .text_byte_i   (in_byte_q),
    .end_of_text_i (in_eot_q),
    .state_i       (state_q),
    .len_i         (len_q),
    .state_o       (state_d),
    .len_o         (len_d),
    .res_o         (res_pair)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{mode: jts_pkg::MODE_IDLE, lit_pos: 3'd0, lit_choice: jts_pkg::LIT_NULL,
                   hex_value: 16'h0000, hex_seen: 3'd0, failed: 1'b0};
      len_q   <= '0;
    end else if (advance) begin
      state_q <= state_d;
      len_q   <= len_d;
    end
  end

  // events only enter the queue when the request really advances
  always_comb begin
    push          = res_pair;
    push.r0_valid = res_pair.r0_valid && advance;
    push.r1_valid = res_pair.r1_valid && advance;
  end

  jts_result_fifo u_result_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pop_i      (!out_stall_i),
    .room_two_o (room_two),
    .valid_o    (out_valid_o),
    .head_o     (head)
  );

  assign token_kind_o   = head.token_kind;
  assign char_value_o   = head.char_value;
  assign token_length_o = head.token_length;
  assign last_o         = head.last;

`ifndef SYNTHESIS
  // end of text always brings the scanner back to its reset state
  a_eot_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_eot_q) |=>
      (state_q.mode == jts_pkg::MODE_IDLE && !state_q.failed && len_q == '0))
    else $error("scanner state not cleared after end of text");

  // a failed scanner drops text bytes silently
  a_failed_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && state_q.failed && !in_eot_q) |-> !res_pair.r0_valid)
    else $error("event produced while failed");

  // two events come in order with last on the second only
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_pair.r1_valid |->
      (res_pair.r0_valid && !res_pair.r0.last && res_pair.r1.last))
    else $error("malformed event pair");

  // single events always carry last
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_pair.r0_valid && !res_pair.r1_valid) |-> res_pair.r0.last)
    else $error("single event without last");
`endif

endmodule
`default_nettype wire

>>> tb/sv/json_token_scanner_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_token_scanner_tb: self-checking testbench of the json token scanner
// a short table of hand-picked bytes, then random json-like documents with
// broken pieces and noise, fed under four idle/stall mixes; every token event
// is checked field by field against its table row or a scanner in the bench
// ----------------------------------------------------------------------------
module json_token_scanner_tb;
  import jts_pkg::*;

  localparam int unsigned LEN_BITS     = 16;
  localparam logic [15:0] LEN_CAP      = (LEN_BITS >= 16) ? 16'hffff
                                         : 16'((1 << LEN_BITS) - 1);
  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned DRAIN_SLACK  = 8;
  localparam int unsigned END_SLACK    = 20;
  localparam int unsigned TIMEOUT_NS   = 10_000_000;

  // how a table row is checked
  typedef enum {ROW_MODEL, ROW_QUIET, ROW_ONE} row_e;
  // what the random generator builds next
  typedef enum {PIECE_MARK, PIECE_STRING, PIECE_NUMBER, PIECE_WORD} piece_e;

  typedef struct {
    logic [7:0]  text;
    logic        eot;
    row_e        check;
    token_kind_e kind;
  } table_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  text_byte_i;
  logic        end_of_text_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  token_kind_o;
  logic [7:0]  char_value_o;
  logic [15:0] token_length_o;
  logic        last_o;

  json_token_scanner #(
    .LENGTH_BITS(LEN_BITS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .token_kind_o  (token_kind_o),
    .char_value_o  (char_value_o),
    .token_length_o(token_length_o),
    .last_o        (last_o)
  );

  // scanner state as the bench sees it
  scan_mode_e  mode_q;
  logic [2:0]  lit_pos_q;
  lit_choice_e lit_sel_q;
  logic [15:0] hex_acc_q;
  logic [2:0]  hex_cnt_q;
  logic [15:0] run_len_q;
  logic        dead_q;

  // events of the current request, then the queue of events still due
  result_t     step_res [2];
  int          step_cnt;
  result_t     expected_tokens [$];

  int          error_count      = 0;
  int          counted_requests = 0;
  int unsigned send_idle_pct    = 0;
  int unsigned stall_pct        = 0;

  logic [8:0]  text_run [$];  // {end of text, byte} in send order
  logic [7:0]  piece_q [$];
  table_row_t  plan [$];

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // token prediction
  // --------------------------------------------------------------------------
  task automatic put_token(input token_kind_e kind, input logic [7:0] ch,
                           input logic [15:0] len);
    step_res[step_cnt] = '{token_kind: kind, char_value: ch, token_length: len,
                           last: 1'b0};
    step_cnt++;
  endtask

  task automatic clear_scanner();
    mode_q    = MODE_IDLE;
    lit_pos_q = '0;
    lit_sel_q = LIT_NULL;
    hex_acc_q = '0;
    hex_cnt_q = '0;
    run_len_q = '0;
    dead_q    = 1'b0;
  endtask

  // saturating length of the open string or number
  task automatic bump_length();
    if (run_len_q < LEN_CAP) run_len_q++;
  endtask

  // invalid event; everything after it is dropped until end of text
  task automatic reject_byte();
    put_token(TOK_INVALID, 8'h00, 16'h0);
    dead_q = 1'b1;
    mode_q = MODE_IDLE;
  endtask

  task automatic add_char(input logic [7:0] c);
    bump_length();
    put_token(TOK_STRCHAR, c, 16'h0);
    mode_q = MODE_STR;
  endtask

  function automatic logic dec_digit(input logic [7:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

  // letters a-f and A-F give their low nibble plus 9
  task automatic hex_nibble(input logic [7:0] b, output logic ok, output logic [3:0] v);
    ok = 1'b1;
    if (dec_digit(b)) begin
      v = b[3:0];
    end else if ((b >= CH_LA && b <= CH_LF_LC) || (b >= CH_UA && b <= CH_UF)) begin
      v = b[3:0] + 4'd9;
    end else begin
      ok = 1'b0;
      v  = 4'h0;
    end
  endtask

  function automatic string spelling_of(input lit_choice_e c);
    case (c)
      LIT_NULL: return "null";
      LIT_TRUE: return "true";
      default:  return "false";
    endcase
  endfunction

  function automatic token_kind_e word_token(input lit_choice_e c);
    case (c)
      LIT_NULL: return TOK_NULL;
      LIT_TRUE: return TOK_TRUE;
      default:  return TOK_FALSE;
    endcase
  endfunction

  // number grammar: next mode, or the byte ends a whole number, or it is bad
  task automatic num_follow(input logic [7:0] b, output logic bad, output logic ends,
                            output scan_mode_e nx);
    logic d;
    logic e;
    d    = dec_digit(b);
    e    = (b == CH_LE) || (b == CH_UE);
    bad  = 1'b0;
    ends = 1'b0;
    nx   = mode_q;
    case (mode_q)
      MODE_SIGN: begin
        if (d) nx = (b == CH_0) ? MODE_ZERO : MODE_INT;
        else bad = 1'b1;
      end
      MODE_ZERO: begin
        // no digit may follow a leading zero
        if (d) bad = 1'b1;
        else if (b == CH_DOT) nx = MODE_DOT;
        else if (e) nx = MODE_EXP;
        else ends = 1'b1;
      end
      MODE_INT: begin
        if (d) nx = MODE_INT;
        else if (b == CH_DOT) nx = MODE_DOT;
        else if (e) nx = MODE_EXP;
        else ends = 1'b1;
      end
      MODE_DOT: begin
        if (d) nx = MODE_FRAC;
        else bad = 1'b1;
      end
      MODE_FRAC: begin
        if (d) nx = MODE_FRAC;
        else if (e) nx = MODE_EXP;
        else ends = 1'b1;
      end
      MODE_EXP: begin
        if (b == CH_PLUS || b == CH_MINUS) nx = MODE_EXPSIGN;
        else if (d) nx = MODE_EXPDIG;
        else bad = 1'b1;
      end
      MODE_EXPSIGN: begin
        if (d) nx = MODE_EXPDIG;
        else bad = 1'b1;
      end
      default: begin
        if (d) nx = MODE_EXPDIG;
        else ends = 1'b1;
      end
    endcase
  endtask

  // a byte between tokens
  task automatic scan_idle(input logic [7:0] b);
    if (b == CH_SPACE || b == CH_CR || b == CH_LF || b == CH_TAB) return;
    run_len_q = '0;
    case (b)
      CH_LBRACE: put_token(TOK_LBRACE, 8'h00, 16'h0);
      CH_RBRACE: put_token(TOK_RBRACE, 8'h00, 16'h0);
      CH_LSQ:    put_token(TOK_LSQUARE, 8'h00, 16'h0);
      CH_RSQ:    put_token(TOK_RSQUARE, 8'h00, 16'h0);
      CH_COMMA:  put_token(TOK_COMMA, 8'h00, 16'h0);
      CH_COLON:  put_token(TOK_COLON, 8'h00, 16'h0);
      CH_QUOTE:  mode_q = MODE_STR;
      CH_LN, CH_LT, CH_LF_LC: begin
        lit_sel_q = (b == CH_LN) ? LIT_NULL : (b == CH_LT) ? LIT_TRUE : LIT_FALSE;
        lit_pos_q = 3'd1;
        mode_q    = MODE_LIT;
      end
      default: begin
        if (b == CH_MINUS || dec_digit(b)) begin
          mode_q = (b == CH_MINUS) ? MODE_SIGN : (b == CH_0) ? MODE_ZERO : MODE_INT;
          bump_length();
          put_token(TOK_NUMCHAR, b, 16'h0);
        end else begin
          reject_byte();
        end
      end
    endcase
  endtask

  // one accepted request: updates the state and fills step_res
  task automatic scan_step(input logic [7:0] b, input logic eot);
    string      word;
    logic       nib_ok;
    logic [3:0] nib;
    logic       bad;
    logic       ends;
    scan_mode_e nx;
    step_cnt = 0;
    if (eot) begin
      // close whatever is open, then back to the reset state
      if (!dead_q) begin
        if (mode_q == MODE_ZERO || mode_q == MODE_INT || mode_q == MODE_FRAC ||
            mode_q == MODE_EXPDIG) begin
          put_token(TOK_NUMEND, 8'h00, run_len_q);
        end else if (mode_q != MODE_IDLE) begin
          put_token(TOK_INVALID, 8'h00, 16'h0);
        end
      end
      put_token(TOK_END, 8'h00, 16'h0);
      clear_scanner();
    end else if (!dead_q) begin
      case (mode_q)
        MODE_IDLE: scan_idle(b);
        MODE_LIT: begin
          word = spelling_of(lit_sel_q);
          if (lit_pos_q < word.len() && b == word[lit_pos_q]) begin
            lit_pos_q++;
            if (lit_pos_q == word.len()) begin
              put_token(word_token(lit_sel_q), 8'h00, 16'h0);
              mode_q = MODE_IDLE;
            end
          end else begin
            reject_byte();
          end
        end
        MODE_STR: begin
          if (b == CH_QUOTE) begin
            put_token(TOK_STREND, 8'h00, run_len_q);
            mode_q = MODE_IDLE;
          end else if (b <= CTRL_MAX) begin
            reject_byte();
          end else if (b == CH_BSLASH) begin
            mode_q = MODE_ESC;
          end else begin
            add_char(b);
          end
        end
        MODE_ESC: begin
          case (b)
            CH_QUOTE, CH_SLASH, CH_BSLASH: add_char(b);
            CH_LB:    add_char(CH_BS);
            CH_LF_LC: add_char(CH_FF);
            CH_LN:    add_char(CH_LF);
            CH_LR:    add_char(CH_CR);
            CH_LT:    add_char(CH_TAB);
            CH_LU: begin
              hex_acc_q = '0;
              hex_cnt_q = '0;
              mode_q    = MODE_HEX;
            end
            default:  reject_byte();
          endcase
        end
        MODE_HEX: begin
          hex_nibble(b, nib_ok, nib);
          if (!nib_ok) begin
            reject_byte();
          end else begin
            hex_acc_q = {hex_acc_q[11:0], nib};
            hex_cnt_q++;
            // only code points up to one byte are accepted
            if (hex_cnt_q >= 3'd4) begin
              if (hex_acc_q <= BYTE_MAX) add_char(hex_acc_q[7:0]);
              else reject_byte();
            end
          end
        end
        default: begin
          num_follow(b, bad, ends, nx);
          if (bad) begin
            reject_byte();
          end else if (ends) begin
            // the ending byte is scanned again as the start of a token
            put_token(TOK_NUMEND, 8'h00, run_len_q);
            mode_q = MODE_IDLE;
            scan_idle(b);
          end else begin
            mode_q = nx;
            bump_length();
            put_token(TOK_NUMCHAR, b, 16'h0);
          end
        end
      endcase
    end
    if (step_cnt > 0) step_res[step_cnt-1].last = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // request side: drive on the falling edge, accept on the rising edge
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [7:0] b, input logic eot, input logic use_model);
    @(negedge clk_i);
    // random idle cycles with junk on the payload
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i    <= 1'b0;
      text_byte_i   <= 8'($urandom_range(255));
      end_of_text_i <= 1'($urandom_range(1));
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (in_stall_o);
    scan_step(b, eot);
    counted_requests++;
    if (use_model) begin
      for (int i = 0; i < step_cnt; i++) expected_tokens.push_back(step_res[i]);
    end
  endtask

  // sender holds off until every due event has come out
  task automatic hold_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(posedge clk_i);
  endtask

  task automatic play_text();
    logic [8:0] req;
    while (text_run.size() != 0) begin
      req = text_run.pop_front();
      send_request(req[7:0], req[8], 1'b1);
    end
  endtask

  // --------------------------------------------------------------------------
  // random json-like text
  // --------------------------------------------------------------------------
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return CH_0 + 8'(v);
    return (($urandom_range(1) != 0) ? CH_UA : CH_LA) + 8'(v) - 8'd10;
  endfunction

  task automatic make_string(input int unsigned len);
    int unsigned sel;
    int unsigned v;
    logic [7:0]  c;
    piece_q.push_back(CH_QUOTE);
    repeat (len) begin
      sel = $urandom_range(99);
      if (sel < 65) begin
        // plain character, high half included
        do c = 8'($urandom_range(8'hff, 8'h20)); while (c == CH_QUOTE || c == CH_BSLASH);
        piece_q.push_back(c);
      end else if (sel < 82) begin
        piece_q.push_back(CH_BSLASH);
        case ($urandom_range(7))
          0:       piece_q.push_back(CH_QUOTE);
          1:       piece_q.push_back(CH_SLASH);
          2:       piece_q.push_back(CH_BSLASH);
          3:       piece_q.push_back(CH_LB);
          4:       piece_q.push_back(CH_LF_LC);
          5:       piece_q.push_back(CH_LN);
          6:       piece_q.push_back(CH_LR);
          default: piece_q.push_back(CH_LT);
        endcase
      end else if (sel < 95) begin
        // \u escape, now and then above one byte
        piece_q.push_back(CH_BSLASH);
        piece_q.push_back(CH_LU);
        v = (sel < 92) ? $urandom_range(255) : $urandom_range(16'hffff);
        for (int k = 3; k >= 0; k--) piece_q.push_back(hex_char(4'(v >> (4 * k))));
      end else if (sel < 97) begin
        // raw control byte
        piece_q.push_back(8'($urandom_range(CTRL_MAX)));
      end else begin
        // escape with any byte, mostly unknown
        piece_q.push_back(CH_BSLASH);
        piece_q.push_back(8'($urandom_range(255)));
      end
    end
    piece_q.push_back(CH_QUOTE);
  endtask

  task automatic make_number();
    if ($urandom_range(3) == 0) piece_q.push_back(CH_MINUS);
    if ($urandom_range(4) == 0) begin
      piece_q.push_back(CH_0);
    end else begin
      piece_q.push_back(8'(CH_0 + $urandom_range(9, 1)));
      repeat ($urandom_range(3)) piece_q.push_back(8'(CH_0 + $urandom_range(9)));
    end
    if ($urandom_range(2) == 0) begin
      piece_q.push_back(CH_DOT);
      repeat ($urandom_range(3, 1)) piece_q.push_back(8'(CH_0 + $urandom_range(9)));
    end
    if ($urandom_range(3) == 0) begin
      piece_q.push_back(($urandom_range(1) != 0) ? CH_LE : CH_UE);
      case ($urandom_range(2))
        0:       piece_q.push_back(CH_PLUS);
        1:       piece_q.push_back(CH_MINUS);
        default: ;
      endcase
      repeat ($urandom_range(2, 1)) piece_q.push_back(8'(CH_0 + $urandom_range(9)));
    end
  endtask

  task automatic make_word();
    string       w;
    int unsigned k;
    case ($urandom_range(2))
      0:       w = "null";
      1:       w = "true";
      default: w = "false";
    endcase
    for (int i = 0; i < w.len(); i++) piece_q.push_back(w[i]);
    // misspelled literal now and then
    if ($urandom_range(19) == 0) begin
      k = $urandom_range(w.len() - 1, 1);
      piece_q[k] = 8'($urandom_range(8'h7a, CH_LA));
    end
  endtask

  // mostly well-formed tokens; some cut short, some stray bytes
  task automatic make_document();
    piece_e      pick;
    int unsigned keep;
    repeat ($urandom_range(12, 1)) begin
      if ($urandom_range(2) == 0) begin
        repeat ($urandom_range(3, 1)) begin
          case ($urandom_range(3))
            0:       text_run.push_back({1'b0, CH_SPACE});
            1:       text_run.push_back({1'b0, CH_CR});
            2:       text_run.push_back({1'b0, CH_LF});
            default: text_run.push_back({1'b0, CH_TAB});
          endcase
        end
      end
      piece_q.delete();
      pick = piece_e'($urandom_range(PIECE_WORD));
      case (pick)
        PIECE_MARK: begin
          case ($urandom_range(5))
            0:       piece_q.push_back(CH_LBRACE);
            1:       piece_q.push_back(CH_RBRACE);
            2:       piece_q.push_back(CH_LSQ);
            3:       piece_q.push_back(CH_RSQ);
            4:       piece_q.push_back(CH_COMMA);
            default: piece_q.push_back(CH_COLON);
          endcase
        end
        PIECE_STRING: begin
          make_string(($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(6));
        end
        PIECE_NUMBER: make_number();
        default:      make_word();
      endcase
      keep = piece_q.size();
      if ($urandom_range(19) == 0) keep = $urandom_range(piece_q.size(), 1);
      for (int i = 0; i < keep; i++) text_run.push_back({1'b0, piece_q[i]});
      if ($urandom_range(29) == 0) text_run.push_back({1'b0, 8'($urandom_range(255))});
    end
    // most documents are closed; the byte beside end of text is junk
    if ($urandom_range(99) < 85) text_run.push_back({1'b1, 8'($urandom_range(255))});
  endtask

  // --------------------------------------------------------------------------
  // result side: random stall, checks against the oldest due event
  // --------------------------------------------------------------------------
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic flag_error(input string what);
    error_count++;
    $display("%0t ns  mismatch: %s", $time, what);
  endtask

  always @(posedge clk_i) begin : watch_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_tokens.size() == 0) begin
        flag_error($sformatf("token kind %0d with nothing due", token_kind_o));
      end else begin
        want = expected_tokens.pop_front();
        if (token_kind_o !== want.token_kind)
          flag_error($sformatf("token_kind %0d, expected %0d", token_kind_o, want.token_kind));
        if (char_value_o !== want.char_value)
          flag_error($sformatf("char_value %0h, expected %0h", char_value_o, want.char_value));
        if (token_length_o !== want.token_length)
          flag_error($sformatf("token_length %0d, expected %0d", token_length_o,
                               want.token_length));
        if (last_o !== want.last)
          flag_error($sformatf("last %0b, expected %0b", last_o, want.last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int goal;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    text_byte_i   = 8'h00;
    end_of_text_i = 1'b0;
    clear_scanner();

    // directed rows; ROW_ONE rows carry the single event they must give
    plan.push_back('{8'hff, 1'b1, ROW_ONE, TOK_END});         // end right after reset
    plan.push_back('{8'h00, 1'b0, ROW_ONE, TOK_INVALID});     // lowest byte fits nothing
    plan.push_back('{8'hff, 1'b0, ROW_QUIET, TOK_END});       // dropped while failed
    plan.push_back('{8'h00, 1'b1, ROW_ONE, TOK_END});         // end only after a failure
    plan.push_back('{CH_LBRACE, 1'b0, ROW_ONE, TOK_LBRACE});
    plan.push_back('{CH_RBRACE, 1'b0, ROW_ONE, TOK_RBRACE});
    plan.push_back('{CH_LSQ, 1'b0, ROW_ONE, TOK_LSQUARE});
    plan.push_back('{CH_RSQ, 1'b0, ROW_ONE, TOK_RSQUARE});
    plan.push_back('{CH_COMMA, 1'b0, ROW_ONE, TOK_COMMA});
    plan.push_back('{CH_COLON, 1'b0, ROW_ONE, TOK_COLON});
    plan.push_back('{CH_TAB, 1'b0, ROW_QUIET, TOK_END});      // whitespace skipped
    plan.push_back('{CH_QUOTE, 1'b0, ROW_QUIET, TOK_END});
    plan.push_back('{8'hff, 1'b0, ROW_MODEL, TOK_END});       // top byte as a character
    plan.push_back('{CH_BSLASH, 1'b0, ROW_QUIET, TOK_END});
    plan.push_back('{CH_LU, 1'b0, ROW_QUIET, TOK_END});
    plan.push_back('{CH_0, 1'b0, ROW_QUIET, TOK_END});
    plan.push_back('{CH_0, 1'b0, ROW_QUIET, TOK_END});
    plan.push_back('{CH_LF_LC, 1'b0, ROW_QUIET, TOK_END});
    plan.push_back('{CH_UF, 1'b0, ROW_MODEL, TOK_END});       // \u00fF, largest allowed
    plan.push_back('{CH_QUOTE, 1'b0, ROW_MODEL, TOK_END});    // string end, length two
    plan.push_back('{CH_MINUS, 1'b0, ROW_MODEL, TOK_END});
    plan.push_back('{CH_0, 1'b0, ROW_MODEL, TOK_END});
    plan.push_back('{CH_0, 1'b0, ROW_ONE, TOK_INVALID});      // digit after leading zero
    plan.push_back('{8'h00, 1'b1, ROW_ONE, TOK_END});
    plan.push_back('{CH_9, 1'b0, ROW_MODEL, TOK_END});
    plan.push_back('{CH_COMMA, 1'b0, ROW_MODEL, TOK_END});    // number end plus comma
    plan.push_back('{8'h55, 1'b1, ROW_ONE, TOK_END});

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      send_request(plan[i].text, plan[i].eot, plan[i].check == ROW_MODEL);
      if (plan[i].check == ROW_ONE) begin
        expected_tokens.push_back('{token_kind: plan[i].kind, char_value: 8'h00,
                                    token_length: '0, last: 1'b1});
      end
    end
    hold_until_drained();

    // random documents under each idle/stall mix, drained in between
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 52;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 52;
        end
        default: begin
          send_idle_pct = 27;
          stall_pct     = 27;
        end
      endcase
      goal = counted_requests + RANDOM_ITEMS / 4;
      while (counted_requests < goal) begin
        make_document();
        play_text();
      end
      hold_until_drained();
    end

    // nothing due any more; watch a little longer for stray events
    repeat (END_SLACK) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** json_token_scanner: PASSED **");
    end else begin
      $display("** json_token_scanner: FAILED **");
    end
    $finish;
  end

  // hard stop if the run hangs
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("** json_token_scanner: FAILED **");
    $finish;
  end

endmodule

>>> json_token_scanner.f
design/jts_pkg.sv
design/jts_scan_core.sv
design/jts_result_fifo.sv
design/json_token_scanner.sv
tb/sv/json_token_scanner_tb.sv
